/* rtl/core/lcfc_pkg.sv */
// Shared types and constants for the length-prefixed CRC-32C frame checker.
package lcfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_W    = 25;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned HDR_CNT_W = 3;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // Reset value of the maximum payload length register
    localparam logic [CFG_W-1:0] CFG_MAX_LEN_RESET = 25'd65536;

    // Header byte positions: length in the first four, CRC in the next four
    localparam logic [HDR_CNT_W-1:0] HDR_LEN_BYTES = 3'd4;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST      = 3'd7;

    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_CLOSE = 1'b1
    } op_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_TOO_LONG     = 3'd1,
        ST_CRC_MISMATCH = 3'd2,
        ST_CLOSED_HDR   = 3'd3,
        ST_CLOSED_PAY   = 3'd4,
        ST_ALREADY_SHUT = 3'd5
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data_byte;
    } lcfc_in_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        status_t           status;
    } lcfc_out_t;

    // Result of one processed transaction, with its presence flag
    typedef struct packed {
        logic      valid;
        lcfc_out_t item;
    } lcfc_res_t;

endpackage

/* rtl/core/lcfc_crc_byte.sv */
// Byte-wide CRC-32C (reflected) update.
module lcfc_crc_byte import lcfc_pkg::*; (
    input  logic [CRC_W-1:0]  crc_in,
    input  logic [BYTE_W-1:0] data_in,
    output logic [CRC_W-1:0]  crc_out
);

    always_comb begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
        for (int i = 0; i < BYTE_W; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        crc_out = c;
    end

endmodule

/* rtl/core/lcfc_parser.sv */
// Frame parser: header capture, payload count, CRC check and close handling.
module lcfc_parser import lcfc_pkg::*; #(
    parameter int unsigned LEFT_W = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  lcfc_in_t         item,
    input  logic [CFG_W-1:0] limit,
    output lcfc_res_t        res
);

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_PENDING = 4'b0100,
        PH_CLOSED  = 4'b1000
    } phase_t;

    phase_t                 phase_reg,   phase_next;
    logic [HDR_CNT_W-1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_W-1:0]       frame_len_reg, frame_len_next;
    logic [CRC_W-1:0]       exp_crc_reg, exp_crc_next;
    logic [LEFT_W-1:0]      left_reg,    left_next;
    logic [CRC_W-1:0]       crc_reg,     crc_next;

    logic [CRC_W-1:0]       crc_upd;
    logic [LEN_W-1:0]       len_shift;
    logic [CRC_W-1:0]       exp_shift;
    logic                   pend_ok;

    lcfc_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (item.data_byte),
        .crc_out (crc_upd)
    );

    assign len_shift = {frame_len_reg[LEN_W-BYTE_W-1:0], item.data_byte};
    assign exp_shift = {exp_crc_reg[CRC_W-BYTE_W-1:0], item.data_byte};
    assign pend_ok   = (~crc_reg == exp_crc_reg);

    always_comb begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        frame_len_next = frame_len_reg;
        exp_crc_next   = exp_crc_reg;
        left_next      = left_reg;
        crc_next       = crc_reg;
        res            = '0;
        res.item.kind  = KIND_STATUS;

        unique case (phase_reg)
            PH_HEADER: begin
                if (item.op == OP_CLOSE) begin
                    phase_next      = PH_CLOSED;
                    res.valid       = 1'b1;
                    res.item.status = ST_CLOSED_HDR;
                end else begin
                    if (hdr_cnt_reg < HDR_LEN_BYTES) begin
                        frame_len_next = len_shift;
                    end else begin
                        exp_crc_next = exp_shift;
                    end
                    if (hdr_cnt_reg != HDR_LAST) begin
                        hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    end else begin
                        // Header complete: length fixed, CRC just assembled
                        hdr_cnt_next = '0;
                        crc_next     = CRC_INIT;
                        if (frame_len_reg > LEN_W'(limit)) begin
                            phase_next      = PH_CLOSED;
                            res.valid       = 1'b1;
                            res.item.status = ST_TOO_LONG;
                        end else if (frame_len_reg == '0) begin
                            // Empty payload: CRC of nothing is zero
                            res.valid = 1'b1;
                            if (exp_shift == '0) begin
                                res.item.status = ST_OK;
                            end else begin
                                res.item.status = ST_CRC_MISMATCH;
                                phase_next      = PH_CLOSED;
                            end
                        end else begin
                            left_next  = frame_len_reg[LEFT_W-1:0];
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                res.valid = 1'b1;
                if (item.op == OP_CLOSE) begin
                    phase_next      = PH_CLOSED;
                    res.item.status = ST_CLOSED_PAY;
                end else begin
                    crc_next              = crc_upd;
                    left_next             = left_reg - LEFT_W'(1);
                    res.item.kind         = KIND_DATA;
                    res.item.payload_byte = item.data_byte;
                    if (left_reg == LEFT_W'(1)) begin
                        phase_next = PH_PENDING;
                    end
                end
            end
            PH_PENDING: begin
                res.valid       = 1'b1;
                res.item.status = pend_ok ? ST_OK : ST_CRC_MISMATCH;
                if (!pend_ok || item.op == OP_CLOSE) begin
                    phase_next = PH_CLOSED;
                end else begin
                    // Good frame: this byte opens the next header
                    phase_next     = PH_HEADER;
                    frame_len_next = len_shift;
                    hdr_cnt_next   = HDR_CNT_W'(1);
                end
            end
            PH_CLOSED: begin
                res.valid       = 1'b1;
                res.item.status = ST_ALREADY_SHUT;
            end
            default: begin
                phase_next = PH_CLOSED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= '0;
            frame_len_reg <= '0;
            exp_crc_reg   <= '0;
            left_reg      <= '0;
            crc_reg       <= CRC_INIT;
        end else if (fire) begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            frame_len_reg <= frame_len_next;
            exp_crc_reg   <= exp_crc_next;
            left_reg      <= left_next;
            crc_reg       <= crc_next;
        end
    end

endmodule

/* rtl/core/length_crc_frame_checker_core.sv */
// Top level of the length-prefixed CRC-32C frame checker.
//
//  channel | ports                               | carries
//  --------+-------------------------------------+-----------------------------------
//  input   | s_valid  s_ready  s_data            | op (byte / peer closed), data_byte
//  result  | m_valid  m_ready  m_data            | kind, payload_byte, status
//  config  | cfg_valid  cfg_ready  cfg_data      | max_payload_bytes (25 bits)
//
// One input transaction a cycle while the result side does not stall; its result,
// if any, passes from the input register through the parser logic into the result
// register, which drives m_valid.
// The parser state updates only as the registered item is taken (result register free
// or emptied), so a stalled m_ready backs up through s_ready without losing anything.
// aresetn is synchronous, active low: header phase, CRC all ones, limit 65536
// (capped by MAX_FRAME_BYTES). cfg_ready is always high.
module length_crc_frame_checker_core import lcfc_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = 16777216
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lcfc_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lcfc_out_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    // Payload countdown only needs to hold the cap itself
    localparam int unsigned LEFT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CFG_W-1:0] LIMIT_CAP = CFG_W'(MAX_FRAME_BYTES);
    localparam logic [CFG_W-1:0] LIMIT_RESET =
        (CFG_MAX_LEN_RESET < LIMIT_CAP) ? CFG_MAX_LEN_RESET : LIMIT_CAP;

    logic             in_valid_reg;
    lcfc_in_t         in_data_reg;
    logic             out_valid_reg;
    lcfc_out_t        out_data_reg;
    logic [CFG_W-1:0] limit_reg;

    logic             out_free;
    logic             fire;
    lcfc_res_t        res;

    // Result register free, or emptied this cycle
    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // Effective limit kept already clamped to the build cap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= (cfg_data < LIMIT_CAP) ? cfg_data : LIMIT_CAP;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    lcfc_parser #(
        .LEFT_W (LEFT_W)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .limit   (limit_reg),
        .res     (res)
    );

    // Result register; header bytes but the eighth leave no result behind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= res.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res.valid) begin
            out_data_reg <= res.item;
        end
    end

endmodule

/* rtl/core/lcfc_checker.sv */
// Port-level checker for the frame checker, with its bind.
module lcfc_checker import lcfc_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input lcfc_out_t        m_data
);

    logic shut_reg;

    // Any error status closes the stream for good
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shut_reg <= 1'b0;
        end else if (m_valid && m_ready && m_data.kind == KIND_STATUS &&
                     m_data.status != ST_OK) begin
            shut_reg <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_DATA |-> m_data.status == ST_OK)
        else $error("payload transaction with non-zero status");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_STATUS |-> m_data.payload_byte == '0)
        else $error("status transaction with non-zero byte");

    a_stay_shut: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && shut_reg |->
            m_data.kind == KIND_STATUS && m_data.status == ST_ALREADY_SHUT)
        else $error("result after close is not already-closed");

endmodule

bind length_crc_frame_checker_core lcfc_checker u_lcfc_checker (.*);

/* sim/length_crc_frame_checker_core_test.sv */
// Self-checking testbench for the length-prefixed CRC-32C frame checker core.
module length_crc_frame_checker_core_test import lcfc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Build cap on the payload length, passed down to the core
    localparam int unsigned CAP_BYTES       = 16777216;
    // Random transactions after the directed table
    localparam int unsigned RANDOM_ITEMS    = 1620;
    // Cycles allowed after the last result for anything still in flight
    localparam int unsigned SETTLE_CYCLES   = 8;
    // Length of the one deliberate back-pressure hold on the result side
    localparam int unsigned PRESSURE_CYCLES = 400;

    // How a directed row is checked: by the predictor, against a typed answer, or not at all
    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_RES
    } chk_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] b;
        chk_t       chk;
        lcfc_out_t  res;
    } stim_row_t;

    // Parser phases of the predictor
    typedef enum logic [1:0] {
        PH_HDR,
        PH_PAY,
        PH_WAIT,
        PH_SHUT
    } parse_phase_t;

    localparam lcfc_out_t NO_RES = '{KIND_DATA, 8'h00, ST_OK};
    localparam lcfc_out_t RES_OK = '{KIND_STATUS, 8'h00, ST_OK};

    // Directed part. First an empty frame: the CRC of no bytes is zero, so the
    // eighth header byte answers ok. Then the nine-byte frame "123456789" with
    // its CRC-32C check value E3069283; each payload byte comes straight back.
    // Its verdict is produced by the first random transaction.
    localparam int unsigned N_DIRECTED = 25;
    localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h00, CHK_RES,  RES_OK},
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h00, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h09, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'hE3, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h06, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h92, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h83, CHK_NONE, NO_RES},
        '{OP_BYTE, 8'h31, CHK_RES,  '{KIND_DATA, 8'h31, ST_OK}},
        '{OP_BYTE, 8'h32, CHK_RES,  '{KIND_DATA, 8'h32, ST_OK}},
        '{OP_BYTE, 8'h33, CHK_RES,  '{KIND_DATA, 8'h33, ST_OK}},
        '{OP_BYTE, 8'h34, CHK_RES,  '{KIND_DATA, 8'h34, ST_OK}},
        '{OP_BYTE, 8'h35, CHK_RES,  '{KIND_DATA, 8'h35, ST_OK}},
        '{OP_BYTE, 8'h36, CHK_RES,  '{KIND_DATA, 8'h36, ST_OK}},
        '{OP_BYTE, 8'h37, CHK_RES,  '{KIND_DATA, 8'h37, ST_OK}},
        '{OP_BYTE, 8'h38, CHK_RES,  '{KIND_DATA, 8'h38, ST_OK}},
        '{OP_BYTE, 8'h39, CHK_RES,  '{KIND_DATA, 8'h39, ST_OK}}
    };

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    lcfc_in_t         s_data;
    logic             m_valid;
    logic             m_ready;
    lcfc_out_t        m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // Predictor state: its own copy of the parser and of the length limit
    parse_phase_t         pred_phase;
    logic [HDR_CNT_W-1:0] pred_hdr_cnt;
    logic [LEN_W-1:0]     pred_len;
    logic [CRC_W-1:0]     pred_exp_crc;
    logic [CFG_W-1:0]     pred_left;
    logic [CRC_W-1:0]     pred_crc;
    logic [CFG_W-1:0]     limit_reg;

    // Results still to come out of the core, oldest first
    lcfc_out_t   due_outputs [$];
    int unsigned mismatch_count;
    int unsigned items_sent;
    bit          tx_quiet;
    bit          rx_quiet;
    bit          pressure_go;
    bit          pressure_done;

    length_crc_frame_checker_core #(
        .MAX_FRAME_BYTES (CAP_BYTES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    // One byte through the reflected Castagnoli CRC
    function automatic logic [CRC_W-1:0] crc32c_step(input logic [CRC_W-1:0] crc,
                                                     input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic status_t crc_verdict();
        return ((pred_crc ^ CRC_INIT) == pred_exp_crc) ? ST_OK : ST_CRC_MISMATCH;
    endfunction

    // Header byte; only the eighth can answer (too long, or an empty frame's verdict)
    function automatic bit absorb_header_byte(input logic [7:0] b, inout lcfc_out_t res);
        logic [LEN_W-1:0] lim;
        if (pred_hdr_cnt < HDR_LEN_BYTES) begin
            pred_len = {pred_len[23:0], b};
        end else begin
            pred_exp_crc = {pred_exp_crc[23:0], b};
        end
        if (pred_hdr_cnt != HDR_LAST) begin
            pred_hdr_cnt = pred_hdr_cnt + 1'b1;
            return 1'b0;
        end
        pred_hdr_cnt = '0;
        lim = (limit_reg < CAP_BYTES) ? LEN_W'(limit_reg) : LEN_W'(CAP_BYTES);
        pred_crc = CRC_INIT;
        if (pred_len > lim) begin
            pred_phase = PH_SHUT;
            res.status = ST_TOO_LONG;
            return 1'b1;
        end
        if (pred_len == 0) begin
            res.status = crc_verdict();
            if (res.status != ST_OK) begin
                pred_phase = PH_SHUT;
            end
            return 1'b1;
        end
        pred_left  = pred_len[CFG_W-1:0];
        pred_phase = PH_PAY;
        return 1'b0;
    endfunction

    // Advances the predictor by one transaction; returns 1 when it yields a result
    function automatic bit parse_event(input lcfc_in_t txn, output lcfc_out_t res);
        lcfc_out_t spare;
        res = '{KIND_STATUS, 8'h00, ST_OK};
        case (pred_phase)
            PH_HDR: begin
                if (txn.op == OP_CLOSE) begin
                    pred_phase = PH_SHUT;
                    res.status = ST_CLOSED_HDR;
                    return 1'b1;
                end
                return absorb_header_byte(txn.data_byte, res);
            end
            PH_PAY: begin
                if (txn.op == OP_CLOSE) begin
                    pred_phase = PH_SHUT;
                    res.status = ST_CLOSED_PAY;
                    return 1'b1;
                end
                pred_crc  = crc32c_step(pred_crc, txn.data_byte);
                pred_left = pred_left - 1'b1;
                if (pred_left == 0) begin
                    pred_phase = PH_WAIT;
                end
                res = '{KIND_DATA, txn.data_byte, ST_OK};
                return 1'b1;
            end
            PH_WAIT: begin
                // Verdict of the finished frame; on ok a byte here starts the next header
                res.status = crc_verdict();
                if (res.status != ST_OK || txn.op == OP_CLOSE) begin
                    pred_phase = PH_SHUT;
                end else begin
                    pred_phase   = PH_HDR;
                    pred_hdr_cnt = '0;
                    spare        = res;
                    void'(absorb_header_byte(txn.data_byte, spare));
                end
                return 1'b1;
            end
            default: begin
                res.status = ST_ALREADY_SHUT;
                return 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------ stimulus side

    // Mostly back to back, often a short pause, now and then a long one
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Predicts one transaction, then offers it until the core takes it.
    // Leaves s_valid high at the accepting edge; wait_idle or a pausing next call lowers it.
    task automatic send_item(input lcfc_in_t txn, input chk_t chk, input lcfc_out_t typed);
        lcfc_out_t   guess;
        bit          has;
        int unsigned gap;
        has = parse_event(txn, guess);
        if (chk == CHK_RES) begin
            due_outputs = {due_outputs, typed};
        end else if (chk == CHK_PRED && has) begin
            due_outputs = {due_outputs, guess};
        end
        items_sent++;
        gap = pick_gap(tx_quiet);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= txn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item('{op: OP_BYTE, data_byte: b}, CHK_PRED, NO_RES);
    endtask

    task automatic send_close();
        send_item('{op: OP_CLOSE, data_byte: 8'($urandom)}, CHK_PRED, NO_RES);
    endtask

    // One frame with random payload. hdr_stop and pay_stop cut it short for the
    // broken-frame cases; corrupt spoils the CRC in the header.
    task automatic send_frame(input logic [LEN_W-1:0] len, input bit corrupt,
                              input int unsigned hdr_stop, input int unsigned pay_stop);
        logic [7:0]       body [$];
        logic [CRC_W-1:0] crc;
        logic [63:0]      hdr;
        crc = CRC_INIT;
        if (len <= 1024) begin
            repeat (len) begin
                body = {body, 8'($urandom)};
                crc  = crc32c_step(crc, body[$]);
            end
        end
        crc = ~crc;
        if (corrupt) begin
            crc = crc ^ (32'($urandom) | 32'd1);
        end
        hdr = {len, crc};
        for (int i = 0; i < 8 && i < hdr_stop; i++) begin
            send_byte(hdr[63-8*i -: 8]);
        end
        for (int i = 0; i < body.size() && i < pay_stop; i++) begin
            send_byte(body[i]);
        end
    endtask

    // Core idle: input lowered, every expected result out, then a few spare cycles
    // since header bytes leave nothing in the queue to wait on
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write transaction; only ever issued while the core is idle
    task automatic write_limit(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = v;
    endtask

    // ---------------------------------------------------------------- main flow

    initial begin
        logic [LEN_W-1:0] eff;
        logic [LEN_W-1:0] len;
        int unsigned      r;
        int unsigned      phase_no;
        int unsigned      tail_len;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '{op: OP_BYTE, data_byte: 8'h00};
        cfg_valid = 1'b0;
        cfg_data  = '0;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        pressure_go = 1'b0;
        items_sent  = 0;

        pred_phase   = PH_HDR;
        pred_hdr_cnt = '0;
        pred_len     = '0;
        pred_exp_crc = '0;
        pred_left    = '0;
        pred_crc     = CRC_INIT;
        limit_reg    = CFG_MAX_LEN_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, run with the reset limit
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item('{op: DIRECTED_ROWS[i].op, data_byte: DIRECTED_ROWS[i].b},
                      DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].res);
        end

        // Random part: phases of well-formed frames, the limit changed between
        // phases. Any error closes the core for good, so errors wait for the tail.
        items_sent = 0;
        phase_no   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       write_limit('0);
                1:       write_limit(25'd1);
                2, 7:    write_limit(25'($urandom_range(2, 48)));
                3:       write_limit(CFG_MAX_LEN_RESET);
                4:       write_limit(25'(CAP_BYTES));
                5:       write_limit('1);
                default: write_limit(25'($urandom));
            endcase
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            // Second phase: result side holds off while the sender keeps pushing
            if (phase_no == 1) begin
                tx_quiet    = 1'b1;
                pressure_go = 1'b1;
            end
            eff = (limit_reg < CAP_BYTES) ? LEN_W'(limit_reg) : LEN_W'(CAP_BYTES);
            repeat ($urandom_range(4, 10)) begin
                r = $urandom_range(0, 9);
                if (eff == 0 || r == 0) begin
                    len = '0;
                end else if (r == 1 && eff <= 64) begin
                    len = eff;     // exactly at the limit
                end else begin
                    len = $urandom_range(1, (eff < 40) ? eff : 40);
                end
                send_frame(len, 1'b0, 8, len);
            end
            phase_no++;
        end

        // Tail: one terminal error picked at random, then traffic on a closed core
        wait_idle();
        write_limit(25'($urandom_range(64, 255)));
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        tail_len = $urandom_range(2, 30);
        case ($urandom_range(0, 4))
            0: begin
                // length over the limit: just past it, or a huge length
                if ($urandom_range(0, 1) != 0) begin
                    send_frame(LEN_W'(limit_reg) + 1, 1'b0, 8, 0);
                end else begin
                    send_frame({8'($urandom_range(1, 255)), 24'($urandom)}, 1'b0, 8, 0);
                end
            end
            1: begin
                // bad CRC, on an empty frame or after a payload
                send_frame(($urandom_range(0, 1) != 0) ? 0 : tail_len, 1'b1, 8, tail_len);
            end
            2: begin
                // peer closes inside a header, possibly right at the frame boundary
                send_frame(0, 1'b0, 8, 0);
                send_frame(tail_len, 1'b0, $urandom_range(0, 7), 0);
                send_close();
            end
            3: begin
                // peer closes before the payload is complete
                send_frame(tail_len, 1'b0, 8, $urandom_range(0, tail_len - 1));
                send_close();
            end
            default: begin
                // peer closes with the verdict still pending
                send_frame(tail_len, 1'b0, 8, tail_len);
                send_close();
            end
        endcase
        for (int i = 0; i < $urandom_range(4, 12); i++) begin
            send_item('{op: (i == 0) ? OP_CLOSE : op_t'($urandom_range(0, 1)),
                        data_byte: 8'($urandom)}, CHK_PRED, NO_RES);
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ----------------------------------------------------------- result side

    // Random stalls on m_ready, plus the one long hold-off counted here
    initial begin
        int unsigned stall;
        m_ready       = 1'b0;
        pressure_done = 1'b0;
        stall         = 0;
        forever begin
            @(posedge aclk);
            if (pressure_go && !pressure_done) begin
                m_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge aclk);
                pressure_done = 1'b1;
                m_ready <= 1'b1;
            end else if (stall != 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = pick_gap(rx_quiet);
            end
        end
    end

    // Each accepted result transaction against the oldest expectation
    initial mismatch_count = 0;

    always @(posedge aclk) begin : result_check
        lcfc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_outputs.size() == 0) begin
                mismatch_count++;
                $display("%0t: result expected none got kind %0d byte %02h status %0d",
                         $time, m_data.kind, m_data.payload_byte, m_data.status);
            end else begin
                want = due_outputs.pop_front();
                if (m_data.kind !== want.kind) begin
                    mismatch_count++;
                    $display("%0t: kind expected %0d got %0d",
                             $time, want.kind, m_data.kind);
                end
                if (m_data.payload_byte !== want.payload_byte) begin
                    mismatch_count++;
                    $display("%0t: payload_byte expected %02h got %02h",
                             $time, want.payload_byte, m_data.payload_byte);
                end
                if (m_data.status !== want.status) begin
                    mismatch_count++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, m_data.status);
                end
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends here
    initial begin
        #12ms;
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lcfc_pkg.sv
rtl/core/lcfc_crc_byte.sv
rtl/core/lcfc_parser.sv
rtl/core/length_crc_frame_checker_core.sv
rtl/core/lcfc_checker.sv
sim/length_crc_frame_checker_core_test.sv
